>>> rtl/ahq_pkg.sv
// Shared types, constants and codes of the aging four-ary max heap.
package ahq_pkg;

  // Fixed widths of the channel payloads, the configuration port and the age, threshold and boost fields.
  localparam int unsigned ModeW     = 2;
  localparam int unsigned ReqW      = 16;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned TopW      = 16;
  localparam int unsigned OccW      = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned AgeW      = 3;
  localparam int unsigned ThrW      = 3;
  localparam int unsigned BoostW    = 8;

  // Defaults for the top-level parameters.
  localparam int unsigned DefCapacity     = 64;
  localparam int unsigned DefPriorityBits = 16;
  localparam int unsigned DefArity        = 4;

  // Reset values of the configuration registers and the saturation limit of the age count.
  localparam logic [ThrW-1:0]   ThrReset   = 3'd4;
  localparam logic [BoostW-1:0] BoostReset = 8'd2;
  localparam logic [AgeW-1:0]   AgeMax     = 3'd7;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_CLEAR   = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_BOOST     = 2'd1,
    CFG_SPARE2    = 2'd2,
    CFG_SPARE3    = 2'd3
  } cfg_idx_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_DECODE,
    OP_UP_TEST,
    OP_UP_CMP,
    OP_EX_ROOT,
    OP_EX_LAST,
    OP_DN_RD,
    OP_DN_CMP,
    OP_DN_PLACE,
    OP_AG_RD,
    OP_AG_WR,
    OP_DONE
  } op_e;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic ins_ok;
    logic ext_ok;
    logic pos_zero;
    logic up_move;
    logic cnt_zero;
    logic dn_end;
    logic found;
    logic age_end;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/ahq_if.sv
// Valid/ready channel interfaces for job requests and results.
interface ahq_req_if;
  import ahq_pkg::*;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [ReqW-1:0]   priority_req;
  modport source (output valid, output mode, output priority_req, input ready);
  modport sink (input valid, input mode, input priority_req, output ready);
endinterface

interface ahq_rsp_if;
  import ahq_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [TopW-1:0]    top_priority;
  logic [OccW-1:0]    occupancy;
  modport source (output valid, output status, output top_priority, output occupancy,
                  input ready);
  modport sink (input valid, input status, input top_priority, input occupancy,
                output ready);
endinterface

>>> rtl/ahq_ctrl.sv
// Sequencing state machine for insert, extract, sift and aging passes.
module ahq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ahq_pkg::dp_status_t st_i,
  output ahq_pkg::op_e        op_o
);
  import ahq_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_UP_TEST  = 4'd2;
  localparam logic [3:0] S_UP_CMP   = 4'd3;
  localparam logic [3:0] S_EX_ROOT  = 4'd4;
  localparam logic [3:0] S_EX_LAST  = 4'd5;
  localparam logic [3:0] S_DN_RD    = 4'd6;
  localparam logic [3:0] S_DN_CMP   = 4'd7;
  localparam logic [3:0] S_DN_PLACE = 4'd8;
  localparam logic [3:0] S_AG_RD    = 4'd9;
  localparam logic [3:0] S_AG_WR    = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and datapath operation.
  always_comb begin
    state_d = state_q;
    op_o    = OP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_ACCEPT;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        op_o = OP_DECODE;
        if (st_i.ins_ok) state_d = S_UP_TEST;
        else if (st_i.ext_ok) state_d = S_EX_ROOT;
        else state_d = S_DONE;
      end
      S_UP_TEST: begin
        op_o    = OP_UP_TEST;
        state_d = st_i.pos_zero ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        op_o    = OP_UP_CMP;
        state_d = st_i.up_move ? S_UP_TEST : S_DONE;
      end
      S_EX_ROOT: begin
        op_o    = OP_EX_ROOT;
        state_d = st_i.cnt_zero ? S_DONE : S_EX_LAST;
      end
      S_EX_LAST: begin
        op_o    = OP_EX_LAST;
        state_d = S_DN_RD;
      end
      S_DN_RD: begin
        op_o    = OP_DN_RD;
        state_d = st_i.dn_end ? S_DN_PLACE : S_DN_CMP;
      end
      S_DN_CMP: begin
        op_o    = OP_DN_CMP;
        state_d = S_DN_RD;
      end
      S_DN_PLACE: begin
        op_o    = OP_DN_PLACE;
        state_d = st_i.found ? S_DN_RD : S_AG_RD;
      end
      S_AG_RD: begin
        op_o    = OP_AG_RD;
        state_d = st_i.age_end ? S_DONE : S_AG_WR;
      end
      S_AG_WR: begin
        op_o    = OP_AG_WR;
        state_d = S_AG_RD;
      end
      S_DONE: begin
        op_o = OP_DONE;
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/ahq_dp.sv
// Heap datapath: entry memory, sift registers, aging logic and result register.
module ahq_dp #(
  parameter int unsigned CAPACITY      = ahq_pkg::DefCapacity,
  parameter int unsigned PRIORITY_BITS = ahq_pkg::DefPriorityBits,
  parameter int unsigned ARITY         = ahq_pkg::DefArity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ahq_pkg::op_e                  op_i,
  output ahq_pkg::dp_status_t           st_o,
  input  logic [ahq_pkg::ModeW-1:0]     mode_i,
  input  logic [ahq_pkg::ReqW-1:0]      priority_req_i,
  input  logic                          cfg_we_i,
  input  logic [ahq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ahq_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ahq_pkg::StatusW-1:0]   status_o,
  output logic [ahq_pkg::TopW-1:0]      top_priority_o,
  output logic [ahq_pkg::OccW-1:0]      occupancy_o
);
  import ahq_pkg::*;

  localparam int unsigned PB   = PRIORITY_BITS;
  localparam int unsigned EW   = PB + AgeW;
  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned KW   = $clog2(ARITY + 1);
  localparam int unsigned CIW  = AW + $clog2(ARITY) + 1;
  localparam int unsigned SW   = PB + BoostW + 1;
  localparam logic [PB-1:0] PrioMax = {PB{1'b1}};

  // Entry memory: {priority, age}, one write and one registered read a cycle.
  logic [EW-1:0] mem [CAPACITY];
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  // Control and configuration registers.
  logic [CNTW-1:0]    cnt_q, cnt_d;
  logic [ThrW-1:0]    thr_q;
  logic [BoostW-1:0]  boost_q;
  logic               out_valid_q, out_valid_d;

  // Working registers of one transaction.
  logic [ModeW-1:0]   mode_q, mode_d;
  logic [PB-1:0]      req_q, req_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [EW-1:0]      val_q, val_d;
  logic [EW-1:0]      best_q, best_d;
  logic [AW-1:0]      best_idx_q, best_idx_d;
  logic               found_q, found_d;
  logic [KW-1:0]      k_q, k_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [CNTW-1:0]    age_i_q, age_i_d;
  logic [StatusW-1:0] res_st_q, res_st_d;
  logic [PB-1:0]      res_top_q, res_top_d;
  logic [StatusW-1:0] out_st_q, out_st_d;
  logic [PB-1:0]      out_top_q, out_top_d;
  logic [CNTW-1:0]    out_occ_q, out_occ_d;

  // Derived values.
  logic [PB+ReqW-1:0] req_ext;
  logic [PB-1:0]      req_p;
  logic [AW-1:0]      parent;
  logic [CIW-1:0]     child;
  logic [PB-1:0]      rd_prio;
  logic [AgeW-1:0]    rd_age;
  logic [SW-1:0]      boost_sum;
  logic [PB-1:0]      aged_prio;
  logic [AgeW-1:0]    aged_age;
  logic [PB+TopW-1:0] top_ext;
  logic [CNTW+OccW-1:0] occ_ext;

  assign req_ext = {{PB{1'b0}}, priority_req_i};
  assign req_p   = req_ext[PB-1:0];
  assign parent  = AW'((pos_q - AW'(1)) / ARITY);
  assign child   = CIW'(pos_q) * CIW'(ARITY) + CIW'(1) + CIW'(k_q);
  assign rd_prio = rdata_q[EW-1:AgeW];
  assign rd_age  = rdata_q[AgeW-1:0];

  // Aging of one entry: boost with saturation once its age reaches the threshold, age count saturating.
  assign boost_sum = SW'(rd_prio) + SW'(boost_q);
  assign aged_prio = (rd_age >= thr_q) ?
                     ((boost_sum > SW'(PrioMax)) ? PrioMax : boost_sum[PB-1:0]) : rd_prio;
  assign aged_age  = (rd_age < AgeMax) ? rd_age + AgeW'(1) : rd_age;

  // Status toward the controller.
  assign st_o.ins_ok   = (mode_q == MODE_INSERT) && (req_q != '0) &&
                         (cnt_q < CNTW'(CAPACITY));
  assign st_o.ext_ok   = (mode_q == MODE_EXTRACT) && (cnt_q != '0);
  assign st_o.pos_zero = (pos_q == '0);
  assign st_o.up_move  = rd_prio < val_q[EW-1:AgeW];
  assign st_o.cnt_zero = (cnt_q == '0);
  assign st_o.dn_end   = (k_q == KW'(ARITY)) || (child >= CIW'(cnt_q));
  assign st_o.found    = found_q;
  assign st_o.age_end  = (age_i_q == cnt_q);
  assign st_o.out_free = !out_valid_q || out_ready_i;

  // Datapath operations.
  always_comb begin
    we          = 1'b0;
    re          = 1'b0;
    waddr       = pos_q;
    raddr       = pos_q;
    wdata       = val_q;
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    req_d       = req_q;
    pos_d       = pos_q;
    val_d       = val_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    found_d     = found_q;
    k_d         = k_q;
    idx_d       = idx_q;
    age_i_d     = age_i_q;
    res_st_d    = res_st_q;
    res_top_d   = res_top_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_st_d    = out_st_q;
    out_top_d   = out_top_q;
    out_occ_d   = out_occ_q;
    unique case (op_i)
      OP_IDLE: ;
      OP_ACCEPT: begin
        mode_d = mode_i;
        req_d  = req_p;
      end
      OP_DECODE: begin
        res_top_d = '0;
        res_st_d  = ST_OK;
        if (st_o.ins_ok) begin
          pos_d = AW'(cnt_q);
          val_d = {req_q, {AgeW{1'b0}}};
          cnt_d = cnt_q + CNTW'(1);
        end else if (st_o.ext_ok) begin
          cnt_d = cnt_q - CNTW'(1);
          re    = 1'b1;
          raddr = '0;
        end else if (mode_q == MODE_INSERT) begin
          res_st_d = (req_q == '0) ? ST_IGNORED : ST_FULL;
        end else if (mode_q == MODE_EXTRACT) begin
          res_st_d = ST_EMPTY;
        end else if (mode_q == MODE_CLEAR) begin
          cnt_d = '0;
        end
      end
      OP_UP_TEST: begin
        if (st_o.pos_zero) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = parent;
        end
      end
      OP_UP_CMP: begin
        we = 1'b1;
        if (st_o.up_move) begin
          wdata = rdata_q;
          pos_d = parent;
        end
      end
      OP_EX_ROOT: begin
        res_top_d = rd_prio;
        if (!st_o.cnt_zero) begin
          re    = 1'b1;
          raddr = AW'(cnt_q);
        end
      end
      OP_EX_LAST: begin
        val_d   = rdata_q;
        best_d  = rdata_q;
        pos_d   = '0;
        k_d     = '0;
        found_d = 1'b0;
      end
      OP_DN_RD: begin
        if (!st_o.dn_end) begin
          re    = 1'b1;
          raddr = child[AW-1:0];
          idx_d = child[AW-1:0];
        end
      end
      OP_DN_CMP: begin
        if (rd_prio > best_q[EW-1:AgeW]) begin
          best_d     = rdata_q;
          best_idx_d = idx_q;
          found_d    = 1'b1;
        end
        k_d = k_q + KW'(1);
      end
      OP_DN_PLACE: begin
        we = 1'b1;
        if (found_q) begin
          wdata   = best_q;
          pos_d   = best_idx_q;
          k_d     = '0;
          found_d = 1'b0;
          best_d  = val_q;
        end else begin
          age_i_d = '0;
        end
      end
      OP_AG_RD: begin
        if (!st_o.age_end) begin
          re    = 1'b1;
          raddr = age_i_q[AW-1:0];
        end
      end
      OP_AG_WR: begin
        we      = 1'b1;
        waddr   = age_i_q[AW-1:0];
        wdata   = {aged_prio, aged_age};
        age_i_d = age_i_q + CNTW'(1);
      end
      OP_DONE: begin
        if (st_o.out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_top_d   = res_top_q;
          out_occ_d   = cnt_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      thr_q       <= ThrReset;
      boost_q     <= BoostReset;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_idx_i == CFG_THRESHOLD)) thr_q <= cfg_data_i[ThrW-1:0];
      if (cfg_we_i && (cfg_idx_i == CFG_BOOST)) boost_q <= cfg_data_i[BoostW-1:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    req_q      <= req_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    found_q    <= found_d;
    k_q        <= k_d;
    idx_q      <= idx_d;
    age_i_q    <= age_i_d;
    res_st_q   <= res_st_d;
    res_top_q  <= res_top_d;
    out_st_q   <= out_st_d;
    out_top_q  <= out_top_d;
    out_occ_q  <= out_occ_d;
  end

  // Result outputs.
  assign top_ext        = {{TopW{1'b0}}, out_top_q};
  assign occ_ext        = {{OccW{1'b0}}, out_occ_q};
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign top_priority_o = top_ext[TopW-1:0];
  assign occupancy_o    = occ_ext[OccW-1:0];

endmodule

>>> rtl/aging_four_ary_max_heap.sv
// Top level of the aging four-ary max heap of jobs.
// Insert: places the job at the end and sifts it up level by level toward the root.
// Extract: takes the root, moves the last job to the root and sifts it down, reading
// each child of a level, then ages every held job; an extract that empties the heap
// skips both. Clear, rejects and no-ops go straight to the result. One transaction at a time;
// the next is accepted while a result waits in its register. Reset (async, active low) empties
// the heap and loads threshold 4 and boost 2.
module aging_four_ary_max_heap #(
  parameter int unsigned CAPACITY      = ahq_pkg::DefCapacity,
  parameter int unsigned PRIORITY_BITS = ahq_pkg::DefPriorityBits,
  parameter int unsigned ARITY         = ahq_pkg::DefArity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ahq_req_if.sink                      in_ch,
  ahq_rsp_if.source                    out_ch,
  input  logic                         cfg_we_i,
  input  logic [ahq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ahq_pkg::CfgDataW-1:0] cfg_data_i
);
  import ahq_pkg::*;

  op_e        op;
  dp_status_t st;

  // Sequencer.
  ahq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .st_i       (st),
    .op_o       (op)
  );

  // Datapath.
  ahq_dp #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .ARITY         (ARITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .st_o           (st),
    .mode_i         (in_ch.mode),
    .priority_req_i (in_ch.priority_req),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .status_o       (out_ch.status),
    .top_priority_o (out_ch.top_priority),
    .occupancy_o    (out_ch.occupancy)
  );

endmodule
